// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle assertion failed.");

`endif

// File: rtl/uatf_pkg.sv
package uatf_pkg;

    localparam int TX_QUEUE_DEPTH = 16;
    localparam int PERIOD_WIDTH   = 16;
    localparam int QPTR_W         = (TX_QUEUE_DEPTH > 1) ? $clog2(TX_QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(TX_QUEUE_DEPTH + 1);

    localparam logic [3:0]              IDLE_CODE   = 4'd15;
    localparam logic [3:0]              DATA_BITS   = 4'd8;
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_INIT = PERIOD_WIDTH'(434);

    localparam logic REG_BIT_PERIOD  = 1'b0;
    localparam logic REG_PORT_ENABLE = 1'b1;

    typedef struct packed {
        logic       rx_line;
        logic       push_valid;
        logic [7:0] push_byte;
    } in_item_t;

    typedef struct packed {
        logic              tx_line;
        logic              rx_valid;
        logic [7:0]        rx_byte;
        logic              push_accepted;
        logic [QCNT_W-1:0] tx_queue_count;
    } out_item_t;

    typedef struct packed {
        logic     line_fall;
        in_item_t item;
    } front_item_t;

    typedef struct packed {
        logic        valid;
        front_item_t data;
    } front_beat_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } out_beat_t;

endpackage

// File: rtl/uatf_front.sv
module uatf_front
    import uatf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output front_beat_t beat,
    input  logic        pop
);

    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        wr_reg;
    logic        rd_reg;
    logic        prev_reg;
    front_item_t slot_reg [2];
    logic        accept;
    logic        take;

    assign in_stall   = (count_reg == 2'd2);
    assign accept     = in_valid && !in_stall;
    assign take       = pop && (count_reg != 2'd0);
    assign beat.valid = (count_reg != 2'd0);
    assign beat.data  = slot_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (accept && !take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!accept && take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            prev_reg  <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                wr_reg   <= ~wr_reg;
                prev_reg <= in_item.rx_line;
            end
            if (take)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_reg] <= '{line_fall: prev_reg & ~in_item.rx_line, item: in_item};
        end
    end

endmodule

// File: rtl/uatf_core.sv
module uatf_core
    import uatf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_sel,
    input  logic [PERIOD_WIDTH-1:0] cfg_value,
    input  front_beat_t             beat,
    output logic                    pop,
    input  logic                    space,
    output out_beat_t               result
);

    logic [PERIOD_WIDTH-1:0] bit_period_reg;
    logic                    port_enable_reg;

    logic [7:0]              mem_reg [TX_QUEUE_DEPTH];
    logic [QPTR_W-1:0]       head_reg, head_next;
    logic [QPTR_W-1:0]       tail_reg, tail_next;
    logic [QCNT_W-1:0]       used_reg, used_next;
    logic [3:0]              tx_idx_reg, tx_idx_next;
    logic [7:0]              tx_shift_reg, tx_shift_next;
    logic [PERIOD_WIDTH-1:0] tx_cnt_reg, tx_cnt_next;
    logic                    tx_run_reg, tx_run_next;
    logic                    tx_level_reg, tx_level_next;
    logic [3:0]              rx_idx_reg, rx_idx_next;
    logic [8:0]              rx_shift_reg, rx_shift_next;
    logic [PERIOD_WIDTH-1:0] rx_cnt_reg, rx_cnt_next;
    logic                    rx_run_reg, rx_run_next;
    logic                    res_valid_reg;
    out_item_t               res_item_reg;

    logic [PERIOD_WIDTH-1:0] full_period;
    logic [PERIOD_WIDTH-1:0] half_raw;
    logic [PERIOD_WIDTH-1:0] half_bit;
    logic                    take;
    logic                    line;
    logic                    tx_fire;
    logic                    rx_fire;
    logic                    again;
    logic                    push_ok;
    logic                    delivered;
    logic [7:0]              byte_out;

    assign full_period = (bit_period_reg == '0) ? PERIOD_WIDTH'(1) : bit_period_reg;
    assign half_raw    = bit_period_reg >> 1;
    assign half_bit    = (half_raw == '0) ? PERIOD_WIDTH'(1) : half_raw;
    assign take        = beat.valid && space;
    assign pop         = take;
    assign line        = beat.data.item.rx_line;
    assign tx_fire     = tx_run_reg && (tx_cnt_reg <= PERIOD_WIDTH'(1));
    assign rx_fire     = rx_run_reg && (rx_cnt_reg <= PERIOD_WIDTH'(1));
    assign result      = '{valid: res_valid_reg, item: res_item_reg};

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        used_next     = used_reg;
        tx_idx_next   = tx_idx_reg;
        tx_shift_next = tx_shift_reg;
        tx_cnt_next   = tx_cnt_reg;
        tx_run_next   = tx_run_reg;
        tx_level_next = tx_level_reg;
        rx_idx_next   = rx_idx_reg;
        rx_shift_next = rx_shift_reg;
        rx_cnt_next   = rx_cnt_reg;
        rx_run_next   = rx_run_reg;
        again         = 1'b0;
        push_ok       = 1'b0;
        delivered     = 1'b0;
        byte_out      = 8'd0;

        // Transmit timer and bit sequencing.
        if (tx_run_reg)
        begin
            tx_cnt_next = tx_fire ? '0 : tx_cnt_reg - PERIOD_WIDTH'(1);
        end
        if (tx_fire)
        begin
            if (tx_idx_reg == IDLE_CODE)
            begin
                if (used_reg != '0)
                begin
                    tx_shift_next = mem_reg[head_reg];
                    head_next     = (head_reg == QPTR_W'(TX_QUEUE_DEPTH - 1)) ?
                                    '0 : head_reg + QPTR_W'(1);
                    used_next     = used_reg - QCNT_W'(1);
                    tx_level_next = 1'b0;
                    tx_idx_next   = 4'd0;
                    again         = 1'b1;
                end
            end
            else if (tx_idx_reg < DATA_BITS)
            begin
                tx_level_next = tx_shift_reg[tx_idx_reg[2:0]];
                tx_idx_next   = tx_idx_reg + 4'd1;
                again         = 1'b1;
            end
            else
            begin
                tx_level_next = 1'b1;
                tx_shift_next = 8'd0;
                tx_idx_next   = IDLE_CODE;
                again         = (used_reg != '0);
            end
            tx_run_next = again;
            tx_cnt_next = again ? full_period : '0;
        end

        // Queue push after the transmit timer.
        if (beat.data.item.push_valid && port_enable_reg &&
            (used_next < QCNT_W'(TX_QUEUE_DEPTH)))
        begin
            push_ok   = 1'b1;
            tail_next = (tail_reg == QPTR_W'(TX_QUEUE_DEPTH - 1)) ?
                        '0 : tail_reg + QPTR_W'(1);
            used_next = used_next + QCNT_W'(1);
            if (!tx_run_next)
            begin
                tx_run_next = 1'b1;
                tx_cnt_next = full_period;
            end
        end

        // Receive timer and sampling.
        if (rx_run_reg)
        begin
            rx_cnt_next = rx_fire ? '0 : rx_cnt_reg - PERIOD_WIDTH'(1);
        end
        if (rx_fire)
        begin
            if (rx_idx_reg == IDLE_CODE)
            begin
                if (!line)
                begin
                    rx_idx_next   = 4'd0;
                    rx_shift_next = 9'd0;
                    rx_run_next   = 1'b1;
                    rx_cnt_next   = full_period;
                end
                else
                begin
                    rx_run_next = 1'b0;
                    rx_cnt_next = '0;
                end
            end
            else if (rx_idx_reg < DATA_BITS)
            begin
                rx_shift_next = {1'b0, line, rx_shift_reg[7:1]};
                rx_idx_next   = rx_idx_reg + 4'd1;
                rx_run_next   = 1'b1;
                rx_cnt_next   = full_period;
            end
            else
            begin
                byte_out    = rx_shift_reg[7:0];
                delivered   = 1'b1;
                rx_idx_next = IDLE_CODE;
                rx_run_next = 1'b0;
                rx_cnt_next = '0;
            end
        end

        // A falling edge on an idle receiver arms the start check.
        if (port_enable_reg && beat.data.line_fall && (rx_idx_next == IDLE_CODE))
        begin
            rx_run_next = 1'b1;
            rx_cnt_next = half_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg  <= PERIOD_INIT;
            port_enable_reg <= 1'b0;
            head_reg        <= '0;
            tail_reg        <= '0;
            used_reg        <= '0;
            tx_idx_reg      <= IDLE_CODE;
            tx_shift_reg    <= 8'd0;
            tx_cnt_reg      <= '0;
            tx_run_reg      <= 1'b0;
            tx_level_reg    <= 1'b1;
            rx_idx_reg      <= IDLE_CODE;
            rx_shift_reg    <= 9'd0;
            rx_cnt_reg      <= '0;
            rx_run_reg      <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            res_valid_reg <= take;
            if (cfg_we)
            begin
                if (cfg_sel == REG_BIT_PERIOD)
                begin
                    bit_period_reg <= cfg_value;
                end
                else
                begin
                    port_enable_reg <= cfg_value[0];
                    if (!cfg_value[0])
                    begin
                        head_reg     <= '0;
                        tail_reg     <= '0;
                        used_reg     <= '0;
                        tx_idx_reg   <= IDLE_CODE;
                        tx_shift_reg <= 8'd0;
                        tx_cnt_reg   <= '0;
                        tx_run_reg   <= 1'b0;
                        tx_level_reg <= 1'b1;
                        rx_idx_reg   <= IDLE_CODE;
                        rx_shift_reg <= 9'd0;
                        rx_cnt_reg   <= '0;
                        rx_run_reg   <= 1'b0;
                    end
                end
            end
            else if (take)
            begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                used_reg     <= used_next;
                tx_idx_reg   <= tx_idx_next;
                tx_shift_reg <= tx_shift_next;
                tx_cnt_reg   <= tx_cnt_next;
                tx_run_reg   <= tx_run_next;
                tx_level_reg <= tx_level_next;
                rx_idx_reg   <= rx_idx_next;
                rx_shift_reg <= rx_shift_next;
                rx_cnt_reg   <= rx_cnt_next;
                rx_run_reg   <= rx_run_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !cfg_we && push_ok)
        begin
            mem_reg[tail_reg] <= beat.data.item.push_byte;
        end
        if (take)
        begin
            res_item_reg <= '{tx_line:        tx_level_next,
                              rx_valid:       delivered,
                              rx_byte:        byte_out,
                              push_accepted:  push_ok,
                              tx_queue_count: used_next};
        end
    end

endmodule

// File: rtl/uatf_out_buf.sv
module uatf_out_buf
    import uatf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  out_beat_t result,
    output logic      space,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_reg;
    logic       rd_reg;
    out_item_t  slot_reg [2];
    logic       take;

    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_reg];
    assign take      = out_valid && !out_stall;
    assign space     = (count_next != 2'd2);

    always_comb
    begin
        count_next = count_reg;
        if (result.valid && !take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!result.valid && take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (result.valid)
            begin
                wr_reg <= ~wr_reg;
            end
            if (take)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            slot_reg[wr_reg] <= result.item;
        end
    end

endmodule

// File: rtl/uart_8n1_transceiver_fifo_top.sv
// UART port with 8 data bits, no parity and one stop bit, with a transmit queue.
// Each input beat is one clock tick of the line: the sampled receive level and
// an optional byte offered to the transmit queue. Each input beat yields exactly
// one output beat: the transmit line level, a received byte when one completes,
// whether the push was taken, and the queue fill.
// Input and output use valid and stall; an item moves when valid is high and
// stall is low. Configuration writes use cfg_valid and cfg_ready (always ready):
// index 0 is the bit period in clock ticks, index 1 the port enable. Write them
// only while no beat is in flight.
// An output beat passes through the input queue, the result register of the tick
// engine and the output buffer, each of which registers it. One beat a cycle is
// taken while the output is not stalled.
// When the output is stalled, the output buffer fills, then the tick engine
// holds and the input queue raises in_stall; no beat is lost.
// After reset the port is closed, the bit period is 434 ticks and the transmit
// line reads high.
module uart_8n1_transceiver_fifo_top
    import uatf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  in_item_t                in_item,
    output logic                    out_valid,
    input  logic                    out_stall,
    output out_item_t               out_item,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_index,
    input  logic [PERIOD_WIDTH-1:0] cfg_data
);

    front_beat_t beat;
    out_beat_t   result;
    logic        pop;
    logic        space;

    assign cfg_ready = 1'b1;

    uatf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .beat     (beat),
        .pop      (pop)
    );

    uatf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_sel   (cfg_index),
        .cfg_value (cfg_data),
        .beat      (beat),
        .pop       (pop),
        .space     (space),
        .result    (result)
    );

    uatf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .space     (space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// File: rtl/uatf_checker.sv
`include "assert_macros.svh"

module uatf_checker
    import uatf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))
    `ASSERT_SAME(a_byte_zero, clk, rst_n, out_valid && !out_item.rx_valid, out_item.rx_byte == 8'd0)
    `ASSERT_SAME(a_count_max, clk, rst_n, out_valid, out_item.tx_queue_count <= QCNT_W'(TX_QUEUE_DEPTH))
    `ASSERT_SAME(a_push_count, clk, rst_n, out_valid && out_item.push_accepted, out_item.tx_queue_count != '0)

endmodule

bind uart_8n1_transceiver_fifo_top uatf_checker u_checker (.*);

// File: test/uart_8n1_transceiver_fifo_top_tb.sv
`timescale 1ns / 1ps

module uart_8n1_transceiver_fifo_top_tb;
    import uatf_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int WATCHDOG_MAX = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    in_item_t                in_item;
    logic                    out_valid;
    logic                    out_stall;
    out_item_t               out_item;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic                    cfg_index;
    logic [PERIOD_WIDTH-1:0] cfg_data;

    logic [7:0]              q_mem [TX_QUEUE_DEPTH];
    int unsigned             q_head;
    int unsigned             q_tail;
    int unsigned             q_used;
    logic [3:0]              tx_index;
    logic [7:0]              tx_bits;
    int unsigned             tx_timer;
    bit                      tx_busy;
    logic                    tx_level;
    logic [3:0]              rx_index;
    logic [8:0]              rx_bits;
    int unsigned             rx_timer;
    bit                      rx_busy;
    logic                    rx_last;
    logic [PERIOD_WIDTH-1:0] period_reg;
    logic                    enable_reg;

    out_item_t               pending_results[$];
    bit                      line_plan[$];
    int unsigned             mismatch_count;
    int unsigned             quiet_cycles;
    bit                      sender_gaps;
    bit                      receiver_stalls;
    bit                      hold_off_req;

    uart_8n1_transceiver_fifo_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int unsigned full_ticks();
        return (period_reg == '0) ? 1 : period_reg;
    endfunction

    function automatic int unsigned half_ticks();
        return ((period_reg >> 1) == '0) ? 1 : (period_reg >> 1);
    endfunction

    function automatic bit timer_fires(inout int unsigned count);
        if (count <= 1)
        begin
            count = 0;
            return 1'b1;
        end
        count = count - 1;
        return 1'b0;
    endfunction

    function automatic void clear_engines();
        foreach (q_mem[i])
            q_mem[i] = '0;
        q_head   = 0;
        q_tail   = 0;
        q_used   = 0;
        tx_index = IDLE_CODE;
        tx_bits  = '0;
        tx_timer = 0;
        tx_busy  = 1'b0;
        tx_level = 1'b1;
        rx_index = IDLE_CODE;
        rx_bits  = '0;
        rx_timer = 0;
        rx_busy  = 1'b0;
    endfunction

    function automatic void reset_prediction();
        period_reg = PERIOD_INIT;
        enable_reg = 1'b0;
        clear_engines();
        rx_last = 1'b1;
    endfunction

    function automatic void apply_reg_write(input logic idx, input logic [PERIOD_WIDTH-1:0] value);
        if (idx == REG_BIT_PERIOD)
            period_reg = value;
        else
        begin
            enable_reg = value[0];
            if (!enable_reg)
                clear_engines();
        end
    endfunction

    function automatic out_item_t predict_line_tick(input in_item_t it);
        out_item_t  res;
        bit         accepted;
        bit         delivered;
        bit         again;
        logic [7:0] got;
        accepted  = 1'b0;
        delivered = 1'b0;
        got       = '0;

        if (tx_busy)
        begin
            if (timer_fires(tx_timer))
            begin
                again = 1'b0;
                if (tx_index == IDLE_CODE)
                begin
                    if (q_used > 0)
                    begin
                        tx_bits  = q_mem[q_head];
                        q_head   = (q_head + 1) % TX_QUEUE_DEPTH;
                        q_used   = q_used - 1;
                        tx_level = 1'b0;
                        tx_index = '0;
                        again    = 1'b1;
                    end
                end
                else if (tx_index < DATA_BITS)
                begin
                    tx_level = tx_bits[tx_index];
                    tx_index = tx_index + 4'd1;
                    again    = 1'b1;
                end
                else
                begin
                    tx_level = 1'b1;
                    tx_bits  = '0;
                    tx_index = IDLE_CODE;
                    again    = (q_used > 0);
                end
                tx_busy  = again;
                tx_timer = again ? full_ticks() : 0;
            end
        end

        if (it.push_valid && enable_reg && q_used < TX_QUEUE_DEPTH)
        begin
            q_mem[q_tail] = it.push_byte;
            q_tail        = (q_tail + 1) % TX_QUEUE_DEPTH;
            q_used        = q_used + 1;
            accepted      = 1'b1;
            if (!tx_busy)
            begin
                tx_busy  = 1'b1;
                tx_timer = full_ticks();
            end
        end

        if (rx_busy)
        begin
            if (timer_fires(rx_timer))
            begin
                again = 1'b0;
                if (rx_index == IDLE_CODE)
                begin
                    if (!it.rx_line)
                    begin
                        rx_index = '0;
                        rx_bits  = '0;
                        again    = 1'b1;
                    end
                end
                else if (rx_index < DATA_BITS)
                begin
                    rx_bits  = {it.rx_line, rx_bits[7:0]};
                    rx_bits  = rx_bits >> 1;
                    rx_index = rx_index + 4'd1;
                    again    = 1'b1;
                end
                else
                begin
                    got       = rx_bits[7:0];
                    rx_index  = IDLE_CODE;
                    delivered = 1'b1;
                end
                rx_busy  = again;
                rx_timer = again ? full_ticks() : 0;
            end
        end

        if (enable_reg && rx_last && !it.rx_line && rx_index == IDLE_CODE)
        begin
            rx_busy  = 1'b1;
            rx_timer = half_ticks();
        end
        rx_last = it.rx_line;

        res.tx_line        = tx_level;
        res.rx_valid       = delivered;
        res.rx_byte        = delivered ? got : 8'h00;
        res.push_accepted  = accepted;
        res.tx_queue_count = QCNT_W'(q_used);
        return res;
    endfunction

    function automatic in_item_t tick_item(input bit line, input bit push, input logic [7:0] data);
        in_item_t it;
        it.rx_line    = line;
        it.push_valid = push;
        it.push_byte  = data;
        return it;
    endfunction

    // Queues the receive line levels for one stretch of line activity at the current bit period.
    function automatic void plan_line_activity();
        int unsigned p;
        int unsigned kind;
        int unsigned b;
        logic [7:0]  data;
        p    = full_ticks();
        kind = $urandom_range(0, 9);
        repeat ($urandom_range(1, 2 * p))
            line_plan.push_back(1'b1);
        if (kind < 7)
        begin
            data = 8'($urandom());
            if ($urandom_range(0, 7) == 0)
                data = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            repeat (p)
                line_plan.push_back(1'b0);
            for (b = 0; b < 8; b++)
                repeat (p)
                    line_plan.push_back(data[b]);
            repeat (p)
                line_plan.push_back(1'b1);
        end
        else if (kind == 7)
        begin
            // A low pulse no longer than half a bit, so the start check sees the line high.
            repeat ($urandom_range(1, (p > 2) ? (p >> 1) - 1 : 1))
                line_plan.push_back(1'b0);
        end
        else if (kind == 8)
        begin
            // A frame cut short after the start bit and a few bits of noise.
            repeat (p)
                line_plan.push_back(1'b0);
            repeat ($urandom_range(1, 4) * p)
                line_plan.push_back(1'($urandom_range(0, 1)));
        end
        else
        begin
            repeat ($urandom_range(2, 12))
                line_plan.push_back(1'($urandom_range(0, 1)));
        end
    endfunction

    task automatic flag_error(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_tick(input out_item_t want, input out_item_t got);
        if (got.tx_line !== want.tx_line)
            flag_error($sformatf("tx_line: expected %0d, got %0d", want.tx_line, got.tx_line));
        if (got.rx_valid !== want.rx_valid)
            flag_error($sformatf("rx_valid: expected %0d, got %0d", want.rx_valid, got.rx_valid));
        if (got.rx_byte !== want.rx_byte)
            flag_error($sformatf("rx_byte: expected %02h, got %02h", want.rx_byte, got.rx_byte));
        if (got.push_accepted !== want.push_accepted)
            flag_error($sformatf("push_accepted: expected %0d, got %0d",
                                 want.push_accepted, got.push_accepted));
        if (got.tx_queue_count !== want.tx_queue_count)
            flag_error($sformatf("tx_queue_count: expected %0d, got %0d",
                                 want.tx_queue_count, got.tx_queue_count));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                flag_error("output beat with no expectation waiting");
            else
                compare_tick(pending_results.pop_front(), out_item);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_MAX)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int unsigned stall_left;
        bit          held;
        stall_left = 0;
        held       = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !held)
            begin
                held      = 1'b1;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall = 1'b0;
                if (receiver_stalls && $urandom_range(0, 4) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    task automatic send_tick(input in_item_t it);
        int unsigned gap;
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        in_item  = it;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_line_tick(it));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic idx, input logic [PERIOD_WIDTH-1:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg_write(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_line_ticks(input int unsigned ticks, input int unsigned push_pct);
        in_item_t it;
        repeat (ticks)
        begin
            if (line_plan.size() == 0)
                plan_line_activity();
            it.rx_line    = line_plan.pop_front();
            it.push_valid = ($urandom_range(0, 99) < push_pct);
            it.push_byte  = 8'($urandom());
            send_tick(it);
        end
    endtask

    task automatic test_closed_port();
        send_tick(tick_item(1'b0, 1'b1, 8'hFF));
        send_tick(tick_item(1'b1, 1'b1, 8'h00));
        send_tick(tick_item(1'b0, 1'b0, 8'h5A));
    endtask

    // The longest bit period keeps the sender busy, so the queue fills and refuses a push.
    // The line toggles meanwhile, so each new falling edge restarts the start check.
    task automatic test_full_queue();
        int unsigned n;
        drain_results();
        write_reg(REG_BIT_PERIOD, 16'hFFFF);
        write_reg(REG_PORT_ENABLE, 16'd1);
        send_tick(tick_item(1'b0, 1'b1, 8'h00));
        send_tick(tick_item(1'b1, 1'b1, 8'hFF));
        for (n = 2; n < TX_QUEUE_DEPTH + 1; n++)
            send_tick(tick_item(n[0], 1'b1, 8'($urandom())));
        drain_results();
        write_reg(REG_PORT_ENABLE, 16'd0);
    endtask

    task automatic test_tiny_period();
        drain_results();
        write_reg(REG_BIT_PERIOD, 16'd0);
        write_reg(REG_PORT_ENABLE, 16'd1);
        send_tick(tick_item(1'b1, 1'b1, 8'h81));
        send_tick(tick_item(1'b0, 1'b0, 8'h00));
        send_tick(tick_item(1'b1, 1'b0, 8'h00));
        send_tick(tick_item(1'b0, 1'b0, 8'h00));
        send_tick(tick_item(1'b0, 1'b0, 8'h00));
        repeat (4)
            send_tick(tick_item(1'($urandom_range(0, 1)), 1'b0, 8'h00));
    endtask

    task automatic test_random_traffic();
        logic [PERIOD_WIDTH-1:0] periods [15];
        int unsigned             i;
        periods = '{2, 3, 2, 4, 5, 1, 2, 6, 3, 11, 2, 4, 7, 2, 3};
        periods[14] = PERIOD_WIDTH'($urandom_range(2, 9));
        for (i = 0; i < 15; i++)
        begin
            drain_results();
            sender_gaps     = ($urandom_range(0, 2) != 0);
            receiver_stalls = ($urandom_range(0, 2) != 0);
            write_reg(REG_BIT_PERIOD, periods[i]);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_PORT_ENABLE, 16'd0);
            write_reg(REG_PORT_ENABLE, 16'd1);
            line_plan.delete();
            send_line_ticks(40, i[0] ? 60 : 8);
        end
    endtask

    task automatic test_back_pressure();
        drain_results();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        write_reg(REG_BIT_PERIOD, 16'd3);
        write_reg(REG_PORT_ENABLE, 16'd1);
        line_plan.delete();
        hold_off_req = 1'b1;
        send_line_ticks(40, 30);
        hold_off_req = 1'b0;
        drain_results();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_item         = '0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_BIT_PERIOD;
        cfg_data        = '0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        hold_off_req    = 1'b0;
        mismatch_count  = 0;
        reset_prediction();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_closed_port();
        test_full_queue();
        test_tiny_period();
        test_random_traffic();
        test_back_pressure();

        drain_results();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
